// ===== rtl/imd_pkg.sv =====
package imd_pkg;

  localparam int unsigned POS_W = 12;

  localparam logic [1:0] KIND_AUDIO   = 2'd0;
  localparam logic [1:0] KIND_LENGTH  = 2'd1;
  localparam logic [1:0] KIND_CONTENT = 2'd2;

  localparam logic [3:0] PREFIX_LEN = 4'd13;
  localparam logic [7:0] CHAR_QUOTE = 8'h27;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    PHASE_AUDIO = 2'b01,
    PHASE_META  = 2'b10
  } phase_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic             block_end;
    logic             found;
    logic [POS_W-1:0] offset;
    logic [POS_W-1:0] length;
  } result_t;

  function automatic logic [7:0] title_key(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h53;
      4'd1:    c = 8'h74;
      4'd2:    c = 8'h72;
      4'd3:    c = 8'h65;
      4'd4:    c = 8'h61;
      4'd5:    c = 8'h6D;
      4'd6:    c = 8'h54;
      4'd7:    c = 8'h69;
      4'd8:    c = 8'h74;
      4'd9:    c = 8'h6C;
      4'd10:   c = 8'h65;
      4'd11:   c = 8'h3D;
      4'd12:   c = 8'h27;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/imd_queue.sv =====
module imd_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int unsigned DEPTH = imd_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/imd_front.sv =====
module imd_front #(
  parameter int unsigned LENGTH_UNIT = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [19:0]         cfg_interval,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  output imd_pkg::item_t      item
);

  localparam int unsigned REM_W = $clog2(255 * LENGTH_UNIT + 1);

  logic [19:0]               interval;
  logic [19:0]               countdown;
  imd_pkg::phase_t           phase;
  logic [REM_W-1:0]          remaining;
  logic [imd_pkg::POS_W-1:0] position;
  logic [REM_W-1:0]          rem_load;

  assign rem_load = REM_W'(in_byte) * REM_W'(LENGTH_UNIT);

  always_comb begin
    item.data = in_byte;
    item.pos  = position;
    item.kind = imd_pkg::KIND_AUDIO;
    item.last = 1'b0;
    if (interval != '0) begin
      if (phase == imd_pkg::PHASE_AUDIO) begin
        if (countdown == '0) begin
          item.kind = imd_pkg::KIND_LENGTH;
          item.last = (rem_load == '0);
        end
      end else begin
        item.kind = imd_pkg::KIND_CONTENT;
        item.last = (remaining == REM_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval  <= '0;
      countdown <= '0;
      phase     <= imd_pkg::PHASE_AUDIO;
      remaining <= '0;
      position  <= '0;
    end else if (cfg_write) begin
      interval  <= cfg_interval;
      countdown <= cfg_interval;
      phase     <= imd_pkg::PHASE_AUDIO;
      remaining <= '0;
      position  <= '0;
    end else if (accept && interval != '0) begin
      case (phase)
        imd_pkg::PHASE_AUDIO: begin
          if (countdown != '0) begin
            countdown <= countdown - 1'b1;
          end else begin
            remaining <= rem_load;
            position  <= '0;
            if (rem_load == '0) begin
              countdown <= interval;
            end else begin
              phase <= imd_pkg::PHASE_META;
            end
          end
        end
        imd_pkg::PHASE_META: begin
          remaining <= remaining - 1'b1;
          position  <= position + 1'b1;
          if (remaining == REM_W'(1)) begin
            phase     <= imd_pkg::PHASE_AUDIO;
            countdown <= interval;
          end
        end
        default: begin
          phase <= imd_pkg::PHASE_AUDIO;
        end
      endcase
    end
  end

endmodule

// ===== rtl/imd_back.sv =====
module imd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             step,
  input  imd_pkg::item_t   item,
  output imd_pkg::result_t result
);

  logic [3:0]                prefix_matched;
  logic                      title_started;
  logic [imd_pkg::POS_W-1:0] title_start;
  logic                      first_quote_seen;
  logic [imd_pkg::POS_W-1:0] first_quote_pos;
  logic                      pair_end_seen;
  logic [imd_pkg::POS_W-1:0] pair_end_pos;
  logic                      quote_pending;

  logic [3:0]                prefix_matched_next;
  logic                      title_started_next;
  logic [imd_pkg::POS_W-1:0] title_start_next;
  logic                      first_quote_seen_next;
  logic [imd_pkg::POS_W-1:0] first_quote_pos_next;
  logic                      pair_end_seen_next;
  logic [imd_pkg::POS_W-1:0] pair_end_pos_next;
  logic                      quote_pending_next;
  logic                      is_content;
  logic                      flush;
  logic [imd_pkg::POS_W-1:0] stop_pos;

  assign is_content = (item.kind == imd_pkg::KIND_CONTENT);
  assign flush      = (item.kind == imd_pkg::KIND_LENGTH) || (is_content && item.last);

  always_comb begin
    prefix_matched_next   = prefix_matched;
    title_started_next    = title_started;
    title_start_next      = title_start;
    first_quote_seen_next = first_quote_seen;
    first_quote_pos_next  = first_quote_pos;
    pair_end_seen_next    = pair_end_seen;
    pair_end_pos_next     = pair_end_pos;
    quote_pending_next    = quote_pending;
    if (is_content) begin
      if (!title_started) begin
        if (prefix_matched < imd_pkg::PREFIX_LEN &&
            item.data == imd_pkg::title_key(prefix_matched)) begin
          prefix_matched_next = prefix_matched + 1'b1;
        end else begin
          prefix_matched_next = (item.data == imd_pkg::title_key(4'd0)) ? 4'd1 : 4'd0;
        end
        if (prefix_matched_next == imd_pkg::PREFIX_LEN) begin
          title_started_next = 1'b1;
          title_start_next   = item.pos + 1'b1;
        end
      end else begin
        if (item.data == imd_pkg::CHAR_SEMI && quote_pending && !pair_end_seen) begin
          pair_end_seen_next = 1'b1;
          pair_end_pos_next  = item.pos - 1'b1;
        end
        if (item.data == imd_pkg::CHAR_QUOTE && !first_quote_seen) begin
          first_quote_seen_next = 1'b1;
          first_quote_pos_next  = item.pos;
        end
        quote_pending_next = (item.data == imd_pkg::CHAR_QUOTE);
      end
    end
  end

  assign stop_pos = pair_end_seen_next ? pair_end_pos_next : first_quote_pos_next;

  always_comb begin
    result.kind      = item.kind;
    result.data      = item.data;
    result.block_end = item.last;
    result.found     = is_content && item.last && title_started_next &&
                       (pair_end_seen_next || first_quote_seen_next);
    result.offset    = result.found ? title_start_next : '0;
    result.length    = result.found ? stop_pos - title_start_next : '0;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      title_start     <= title_start_next;
      first_quote_pos <= first_quote_pos_next;
      pair_end_pos    <= pair_end_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      prefix_matched   <= '0;
      title_started    <= 1'b0;
      first_quote_seen <= 1'b0;
      pair_end_seen    <= 1'b0;
      quote_pending    <= 1'b0;
    end else if (step) begin
      if (flush) begin
        prefix_matched   <= '0;
        title_started    <= 1'b0;
        first_quote_seen <= 1'b0;
        pair_end_seen    <= 1'b0;
        quote_pending    <= 1'b0;
      end else begin
        prefix_matched   <= prefix_matched_next;
        title_started    <= title_started_next;
        first_quote_seen <= first_quote_seen_next;
        pair_end_seen    <= pair_end_seen_next;
        quote_pending    <= quote_pending_next;
      end
    end
  end

endmodule

// ===== rtl/icy_metadata_demux_unit.sv =====
// Stream metadata splitter: one received stream byte per word in, one tagged
// word out per byte.
// Input queue side: drive data_byte with push; the word is taken on a clock
// edge where push is high and full is low.
// Result queue side: while empty is low the oldest result sits on byte_kind,
// out_byte, block_end, title_found, title_offset and title_length; pop takes
// it. Title fields are valid on the word that has block_end set.
// Configuration: meta_interval is written on an edge with cfg_valid high
// (cfg_ready is always high); a write restarts the audio count and drops any
// partial block. Write it only while no words are in flight.
// A pushed word is held in the internal queue, then in the result queue.
// Throughput: one word per cycle (single-step title matcher) with pop high.
// Reset: all queues empty, metadata disabled, every byte tagged as audio.
// When pop is held low the result queue fills, then the internal queue, and
// then full rises; no word is lost and the front keeps counting only what
// it takes.
module icy_metadata_demux_unit #(
  parameter int unsigned LENGTH_UNIT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] meta_interval,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  byte_kind,
  output logic [7:0]  out_byte,
  output logic        block_end,
  output logic        title_found,
  output logic [11:0] title_offset,
  output logic [11:0] title_length
);

  localparam int unsigned ITEM_W   = $bits(imd_pkg::item_t);
  localparam int unsigned RESULT_W = $bits(imd_pkg::result_t);

  logic             cfg_write;
  logic             accept;
  imd_pkg::item_t   front_item;
  imd_pkg::item_t   mid_item;
  logic             mid_empty;
  logic             res_full;
  logic             step;
  imd_pkg::result_t back_result;
  imd_pkg::result_t out_result;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign accept    = push && !full;
  assign step      = !mid_empty && !res_full;

  imd_front #(
    .LENGTH_UNIT(LENGTH_UNIT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_interval(meta_interval),
    .accept      (accept),
    .in_byte     (data_byte),
    .item        (front_item)
  );

  imd_queue #(
    .WIDTH(ITEM_W)
  ) u_mid_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(front_item),
    .full     (full),
    .pop      (step),
    .pop_data (mid_item),
    .empty    (mid_empty)
  );

  imd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .clear (cfg_write),
    .step  (step),
    .item  (mid_item),
    .result(back_result)
  );

  imd_queue #(
    .WIDTH(RESULT_W)
  ) u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (step),
    .push_data(back_result),
    .full     (res_full),
    .pop      (pop),
    .pop_data (out_result),
    .empty    (empty)
  );

  assign byte_kind    = out_result.kind;
  assign out_byte     = out_result.data;
  assign block_end    = out_result.block_end;
  assign title_found  = out_result.found;
  assign title_offset = out_result.offset;
  assign title_length = out_result.length;

endmodule

// ===== tb/tb_icy_metadata_demux_unit.sv =====
`timescale 1ns / 1ps

module tb_icy_metadata_demux_unit;

  localparam int LEN_UNIT = 16;
  localparam string TITLE_KEY = "StreamTitle='";

  typedef enum int {
    STYLE_NOISE,
    STYLE_TITLE,
    STYLE_OPEN,
    STYLE_QUOTE,
    STYLE_INNER,
    STYLE_BROKEN
  } block_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [19:0] meta_interval = '0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  byte_kind;
  logic [7:0]  out_byte;
  logic        block_end;
  logic        title_found;
  logic [11:0] title_offset;
  logic [11:0] title_length;

  always #5 clk = ~clk;

  icy_metadata_demux_unit #(
    .LENGTH_UNIT(LEN_UNIT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .meta_interval(meta_interval),
    .push(push),
    .full(full),
    .data_byte(data_byte),
    .empty(empty),
    .pop(pop),
    .byte_kind(byte_kind),
    .out_byte(out_byte),
    .block_end(block_end),
    .title_found(title_found),
    .title_offset(title_offset),
    .title_length(title_length)
  );

  // demux model state
  logic [19:0] cfg_interval;
  logic        in_block;
  logic [19:0] audio_left;
  logic [15:0] bytes_left;
  logic [15:0] blk_pos;
  logic [15:0] title_pos;
  logic [15:0] quote_pos;
  logic [15:0] pair_pos;
  logic [3:0]  key_hits;
  logic        title_on;
  logic        quote_seen;
  logic        pair_seen;
  logic        last_quote;

  imd_pkg::result_t words_due[$];
  logic [7:0]  stage_q[$];
  bit          steady = 1'b0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned words_checked = 0;
  int unsigned blocks_closed = 0;
  int unsigned titles_seen = 0;

  task automatic clear_title();
    blk_pos = '0;
    key_hits = '0;
    title_pos = '0;
    title_on = 1'b0;
    quote_pos = '0;
    quote_seen = 1'b0;
    pair_pos = '0;
    pair_seen = 1'b0;
    last_quote = 1'b0;
  endtask

  task automatic set_interval(input logic [19:0] v);
    cfg_interval = v;
    audio_left = v;
    in_block = 1'b0;
    bytes_left = '0;
    clear_title();
  endtask

  task automatic scan_title(input logic [7:0] b);
    if (!title_on) begin
      if (key_hits < imd_pkg::PREFIX_LEN && b == TITLE_KEY[key_hits]) begin
        key_hits = key_hits + 4'd1;
      end else begin
        key_hits = (b == TITLE_KEY[0]) ? 4'd1 : 4'd0;
      end
      if (key_hits == imd_pkg::PREFIX_LEN) begin
        title_on = 1'b1;
        title_pos = blk_pos + 16'd1;
      end
    end else begin
      if (b == imd_pkg::CHAR_SEMI && last_quote && !pair_seen) begin
        pair_seen = 1'b1;
        pair_pos = blk_pos - 16'd1;
      end
      if (b == imd_pkg::CHAR_QUOTE && !quote_seen) begin
        quote_seen = 1'b1;
        quote_pos = blk_pos;
      end
      last_quote = (b == imd_pkg::CHAR_QUOTE);
    end
  endtask

  task automatic predict_word(input logic [7:0] b, output imd_pkg::result_t r);
    logic [15:0] stop;
    r = '0;
    r.data = b;
    r.kind = imd_pkg::KIND_AUDIO;
    if (cfg_interval != 0) begin
      if (!in_block) begin
        if (audio_left != 0) begin
          audio_left = audio_left - 20'd1;
        end else begin
          r.kind = imd_pkg::KIND_LENGTH;
          bytes_left = 16'(b * LEN_UNIT);
          clear_title();
          if (bytes_left == 0) begin
            r.block_end = 1'b1;
            audio_left = cfg_interval;
          end else begin
            in_block = 1'b1;
          end
        end
      end else begin
        r.kind = imd_pkg::KIND_CONTENT;
        scan_title(b);
        blk_pos = blk_pos + 16'd1;
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 0) begin
          r.block_end = 1'b1;
          if (title_on && (pair_seen || quote_seen)) begin
            stop = pair_seen ? pair_pos : quote_pos;
            r.found = 1'b1;
            r.offset = title_pos[11:0];
            r.length = 12'(stop - title_pos);
          end
          in_block = 1'b0;
          audio_left = cfg_interval;
          clear_title();
        end
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    imd_pkg::result_t r;
    if (!steady) begin
      while ($urandom_range(99) < 33) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_word(b, r);
    words_due.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_stage();
    foreach (stage_q[i]) send_byte(stage_q[i]);
    stage_q.delete();
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (words_due.size() != 0);
  endtask

  task automatic write_interval(input logic [19:0] v);
    drain();
    cfg_valid <= 1'b1;
    meta_interval <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    set_interval(v);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) stage_q.push_back(s[i]);
  endtask

  task automatic push_title();
    logic [7:0] c;
    repeat ($urandom_range(0, 24)) begin
      c = 8'($urandom_range(8'h20, 8'h7E));
      if (c == imd_pkg::CHAR_QUOTE) c = 8'h2D;
      stage_q.push_back(c);
    end
  endtask

  task automatic add_block(input logic [7:0] lenb, input int unsigned lead);
    int unsigned target;
    block_style_t style;
    bit noisy_pad;
    stage_q.push_back(lenb);
    target = stage_q.size() + lenb * LEN_UNIT;
    repeat (lead) stage_q.push_back(8'($urandom));
    if ($urandom_range(3) == 0) push_text("StreamTit");
    style = block_style_t'($urandom_range(0, 5));
    noisy_pad = (style == STYLE_NOISE) || ($urandom_range(3) == 0);
    case (style)
      STYLE_TITLE: begin
        push_text(TITLE_KEY);
        push_title();
        push_text("';");
        if ($urandom_range(1)) push_text("StreamUrl='';");
      end
      STYLE_OPEN: begin
        push_text(TITLE_KEY);
        push_title();
      end
      STYLE_QUOTE: begin
        push_text(TITLE_KEY);
        push_title();
        push_text("'");
      end
      STYLE_INNER: begin
        push_text(TITLE_KEY);
        push_title();
        push_text("'x");
        push_title();
        push_text("';");
      end
      STYLE_BROKEN: begin
        push_text("StreamTitle=");
        push_title();
        push_text("';");
      end
      default: ;
    endcase
    while (stage_q.size() < target) stage_q.push_back(noisy_pad ? 8'($urandom) : 8'h00);
    while (stage_q.size() > target) void'(stage_q.pop_back());
  endtask

  task automatic run_stream(input logic [19:0] iv, input int unsigned budget);
    int unsigned pick;
    logic [7:0] lenb;
    write_interval(iv);
    if (iv == 0) begin
      repeat (budget) stage_q.push_back(8'($urandom));
    end else begin
      while (stage_q.size() < budget) begin
        repeat (iv) stage_q.push_back(8'($urandom));
        pick = $urandom_range(0, 9);
        if (pick == 0) lenb = 8'd0;
        else if (pick < 8) lenb = 8'($urandom_range(1, 2));
        else lenb = 8'($urandom_range(3, 6));
        add_block(lenb, $urandom_range(0, 12));
      end
    end
    // cut the last frame short; the next interval write drops it
    while (stage_q.size() > budget) void'(stage_q.pop_back());
    send_stage();
  endtask

  task automatic test_disabled();
    stage_q = '{8'h00, 8'hFF, imd_pkg::CHAR_QUOTE, imd_pkg::CHAR_SEMI};
    send_stage();
  endtask

  task automatic test_directed_block();
    write_interval(20'd1);
    stage_q.push_back(8'hA5);
    stage_q.push_back(8'h01);
    push_text("StreamTitle='A';");
    stage_q.push_back(8'h5A);
    stage_q.push_back(8'h00);
    stage_q.push_back(8'hFF);
    send_stage();
  endtask

  task automatic test_drain_pause();
    write_interval(20'd3);
    repeat (3) stage_q.push_back(8'($urandom));
    add_block(8'd2, 4);
    send_stage();
    drain();
    repeat (3) stage_q.push_back(8'($urandom));
    add_block(8'd1, 0);
    send_stage();
  endtask

  task automatic test_random_stream();
    logic [19:0] plan[8];
    plan = '{20'd1, 20'd2, 20'($urandom_range(3, 48)), 20'd0,
             20'($urandom_range(1, 16)), 20'd1, 20'($urandom_range(4, 64)), 20'd2};
    foreach (plan[i]) run_stream(plan[i], 60);
  endtask

  task automatic test_no_idle();
    steady = 1'b1;
    run_stream(20'($urandom_range(1, 8)), 150);
    drain();
    steady = 1'b0;
  endtask

  task automatic test_long_block();
    write_interval(20'd2);
    repeat (2) stage_q.push_back(8'($urandom));
    add_block(8'h20, $urandom_range(440, 500));
    send_stage();
  endtask

  task automatic test_max_interval();
    write_interval(20'hFFFFF);
    repeat (16) stage_q.push_back(8'($urandom));
    send_stage();
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= steady || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    imd_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (words_due.size() == 0) begin
        $error("unexpected word: byte_kind %0d out_byte %0d", byte_kind, out_byte);
        errors++;
      end else begin
        want = words_due.pop_front();
        check_field("byte_kind", want.kind, byte_kind);
        check_field("out_byte", want.data, out_byte);
        check_field("block_end", want.block_end, block_end);
        check_field("title_found", want.found, title_found);
        check_field("title_offset", want.offset, title_offset);
        check_field("title_length", want.length, title_length);
        words_checked++;
        if (want.block_end) blocks_closed++;
        if (want.found) titles_seen++;
      end
    end
  end

  initial begin
    set_interval('0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_disabled();
    test_directed_block();
    test_drain_pause();
    test_random_stream();
    test_no_idle();
    test_long_block();
    test_max_interval();
    drain();
    repeat (4) @(posedge clk);
    $display("run covered %0d stream bytes, %0d words checked, %0d blocks closed, %0d titles",
             bytes_sent, words_checked, blocks_closed, titles_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/imd_pkg.sv
rtl/imd_queue.sv
rtl/imd_front.sv
rtl/imd_back.sv
rtl/icy_metadata_demux_unit.sv
tb/tb_icy_metadata_demux_unit.sv
